// ===== sv/tbf_pkg.sv =====
// Shared types and constants for the cassette tape block framer.
// No dependencies; used by the core and the word formatter under sv/.
package tbf_pkg;

    localparam int MAX_PAYLOAD_DEF = 254;
    localparam int LEADER_LEN_DEF  = 16;
    localparam int CNT_W           = 8;

    localparam logic [7:0] LEADER_BYTE = 8'h01;
    localparam logic [7:0] SYNC_A      = 8'h3c;
    localparam logic [7:0] SYNC_B      = 8'h5a;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_DATA  = 2'd1,
        REQ_END   = 2'd2,
        REQ_NONE  = 2'd3
    } req_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FORM
    } state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] block_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] frame_bytes;
        logic [3:0]  byte_count;
        logic        frame_end;
    } out_item_t;

    // Block header info handed to the word formatter.
    typedef struct packed {
        logic [7:0]       blk_type;
        logic [CNT_W-1:0] count;
        logic [7:0]       csum;
    } hdr_info_t;

endpackage

// ===== sv/k7_tape_block_framer_core.sv =====
// Cassette tape block framer. Append requests store bytes into an internal
// row memory at their final frame position and keep a running 8-bit sum; a
// start request sets the block type and drops held bytes. When MAX_PAYLOAD
// bytes are held, or on an end request, the block (leader, sync bytes, type,
// length, payload, checksum) is sent as 8-byte transfers, earliest byte in the
// low bits. Sending a block takes ceil((LEADER_LEN + count + 5) / 8) output
// words, each a memory read and then a format and load of the output
// register, and waits on m_ready. Input is not taken while a block is being
// sent; the last output word may still be waiting when the next request is
// taken.
module k7_tape_block_framer_core #(
    parameter int MAX_PAYLOAD = tbf_pkg::MAX_PAYLOAD_DEF,
    parameter int LEADER_LEN  = tbf_pkg::LEADER_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbf_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbf_pkg::out_item_t  m_data
);

    localparam int HDR_LEN   = LEADER_LEN + 4;
    localparam int FRAME_MAX = LEADER_LEN + MAX_PAYLOAD + 5;
    localparam int WORDS     = (FRAME_MAX + 7) / 8;
    localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W     = WORD_W + 3;
    localparam int ROWS      = (HDR_LEN + MAX_PAYLOAD + 7) / 8;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W     = tbf_pkg::CNT_W;

    tbf_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         type_reg, type_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic               m_valid_reg, m_valid_next;
    tbf_pkg::out_item_t m_data_reg, m_data_next;

    logic               s_fire;
    logic               wr_en;
    logic [POS_W-1:0]   wr_pos;
    logic [ROW_W-1:0]   rd_row;
    logic [63:0]        rd_data;
    tbf_pkg::hdr_info_t hdr;
    tbf_pkg::out_item_t fmt_item;

    assign s_ready = (state_reg == tbf_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign wr_en   = s_fire && (tbf_pkg::req_e'(s_data.req_type) == tbf_pkg::REQ_DATA);
    assign wr_pos  = POS_W'(HDR_LEN) + POS_W'(cnt_reg);
    assign rd_row  = (32'(word_reg) < ROWS) ? word_reg[ROW_W-1:0] : '0;

    assign hdr.blk_type = type_reg;
    assign hdr.count    = cnt_reg;
    assign hdr.csum     = 8'(8'd0 - sum_reg);

    tbf_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_row  (wr_pos[ROW_W+2:3]),
        .wr_lane (wr_pos[2:0]),
        .wr_byte (s_data.data_byte),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    tbf_fmt #(
        .LEADER_LEN (LEADER_LEN),
        .POS_W      (POS_W)
    ) u_fmt (
        .word_idx (word_reg),
        .row_data (rd_data),
        .hdr      (hdr),
        .item     (fmt_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            type_reg    <= '0;
            word_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
            word_reg    <= word_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        word_next    = word_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            tbf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (tbf_pkg::req_e'(s_data.req_type))
                        tbf_pkg::REQ_START: begin
                            type_next = s_data.block_type;
                            cnt_next  = '0;
                            sum_next  = '0;
                        end
                        tbf_pkg::REQ_DATA: begin
                            cnt_next = cnt_reg + 1'b1;
                            sum_next = sum_reg + s_data.data_byte;
                            if (cnt_next == CNT_W'(MAX_PAYLOAD)) begin
                                word_next  = '0;
                                state_next = tbf_pkg::ST_READ;
                            end
                        end
                        tbf_pkg::REQ_END: begin
                            word_next  = '0;
                            state_next = tbf_pkg::ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tbf_pkg::ST_READ: begin
                // row for word_reg is registered in the store this cycle
                state_next = tbf_pkg::ST_FORM;
            end
            tbf_pkg::ST_FORM: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = fmt_item;
                    m_valid_next = 1'b1;
                    if (fmt_item.frame_end) begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = tbf_pkg::ST_IDLE;
                    end else begin
                        word_next  = word_reg + 1'b1;
                        state_next = tbf_pkg::ST_READ;
                    end
                end
            end
            default: begin
                state_next = tbf_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A read always turns into a format cycle.
    a_read_then_form: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tbf_pkg::ST_READ |=> state_reg == tbf_pkg::ST_FORM)
        else $error("read cycle not followed by format cycle");

    // A full block is always sent, so an idle count stays below the limit.
    a_cnt_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tbf_pkg::ST_IDLE |-> cnt_reg < CNT_W'(MAX_PAYLOAD))
        else $error("payload count reached limit while idle");

    // Only the checksum word may be short.
    a_short_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.frame_end |-> m_data.byte_count == 4'd8)
        else $error("short transfer before end of block");

endmodule

// ===== sv/tbf_store.sv =====
// Payload store: byte-writable rows of eight bytes, one registered row read a cycle.
// Depends on nothing beyond its parameters.
module tbf_store #(
    parameter int ROWS  = 35,
    parameter int ROW_W = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [2:0]       wr_lane,
    input  logic [7:0]       wr_byte,
    input  logic [ROW_W-1:0] rd_row,
    output logic [63:0]      rd_data
);

    logic [63:0] mem [ROWS];
    logic [63:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][{wr_lane, 3'b000} +: 8] <= wr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_row];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tbf_fmt.sv =====
// Builds one 8-byte output word of a tape block from a store row and header info.
// Uses tbf_pkg for constants and the header struct.
module tbf_fmt #(
    parameter int LEADER_LEN = 16,
    parameter int POS_W      = 9
) (
    input  logic [POS_W-4:0]     word_idx,
    input  logic [63:0]          row_data,
    input  tbf_pkg::hdr_info_t   hdr,
    output tbf_pkg::out_item_t   item
);

    localparam int HDR_LEN = LEADER_LEN + 4;

    logic [POS_W-1:0] chk_pos;
    logic [7:0]       len_byte;

    always_comb begin
        logic [POS_W-1:0] pos;
        chk_pos  = POS_W'(HDR_LEN) + POS_W'(hdr.count);
        len_byte = 8'(hdr.count + 8'd2);
        item.frame_bytes = '0;
        for (int j = 0; j < 8; j++) begin
            pos = {word_idx, 3'(j)};
            if (pos < POS_W'(LEADER_LEN)) begin
                item.frame_bytes[8*j +: 8] = tbf_pkg::LEADER_BYTE;
            end else if (pos == POS_W'(LEADER_LEN)) begin
                item.frame_bytes[8*j +: 8] = tbf_pkg::SYNC_A;
            end else if (pos == POS_W'(LEADER_LEN + 1)) begin
                item.frame_bytes[8*j +: 8] = tbf_pkg::SYNC_B;
            end else if (pos == POS_W'(LEADER_LEN + 2)) begin
                item.frame_bytes[8*j +: 8] = hdr.blk_type;
            end else if (pos == POS_W'(LEADER_LEN + 3)) begin
                item.frame_bytes[8*j +: 8] = len_byte;
            end else if (pos < chk_pos) begin
                item.frame_bytes[8*j +: 8] = row_data[8*j +: 8];
            end else if (pos == chk_pos) begin
                item.frame_bytes[8*j +: 8] = hdr.csum;
            end
        end
        item.frame_end  = (word_idx == chk_pos[POS_W-1:3]);
        item.byte_count = item.frame_end ? 4'({1'b0, chk_pos[2:0]} + 4'd1) : 4'd8;
    end

endmodule

// ===== verif/k7_tape_block_framer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for k7_tape_block_framer_core: random requests in, frame words checked.
// Depends on tbf_pkg (sv/tbf_pkg.sv) and the core RTL under sv/.
module k7_tape_block_framer_core_test;

    localparam int ITEM_TARGET   = 350;     // counted requests, one full block included
    localparam int TAIL_ITEMS    = 40;      // last requests run without random idle gaps
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_PRINTED   = 50;

    typedef struct packed {
        logic              hold_for_drain;
        tbf_pkg::in_item_t req;
    } queued_req_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tbf_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tbf_pkg::out_item_t m_data;

    k7_tape_block_framer_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    queued_req_t        req_queue [$];
    tbf_pkg::out_item_t frame_words [$];
    int                 stim_items     = 0;
    int                 mismatch_count = 0;
    int                 word_index     = 0;
    int                 cycle_count    = 0;

    // Block state as the predictor sees it
    logic [7:0]  payload_mem [tbf_pkg::MAX_PAYLOAD_DEF];
    int          held_count = 0;
    logic [7:0]  byte_sum   = '0;
    logic [7:0]  blk_type   = '0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function automatic void send_frame();
        logic [7:0]         frame_buf [$];
        tbf_pkg::out_item_t word;
        int                 pos;
        int                 n;
        for (int i = 0; i < tbf_pkg::LEADER_LEN_DEF; i++)
            frame_buf.push_back(tbf_pkg::LEADER_BYTE);
        frame_buf.push_back(tbf_pkg::SYNC_A);
        frame_buf.push_back(tbf_pkg::SYNC_B);
        frame_buf.push_back(blk_type);
        // a full block wraps the length byte to zero
        frame_buf.push_back(8'(held_count + 2));
        for (int i = 0; i < held_count; i++)
            frame_buf.push_back(payload_mem[i]);
        frame_buf.push_back(8'h00 - byte_sum);
        for (pos = 0; pos < frame_buf.size(); pos += 8) begin
            n = (frame_buf.size() - pos > 8) ? 8 : frame_buf.size() - pos;
            word = '0;
            for (int i = 0; i < n; i++)
                word.frame_bytes[8*i +: 8] = frame_buf[pos + i];
            word.byte_count = 4'(n);
            word.frame_end  = (pos + n == frame_buf.size());
            frame_words.push_back(word);
        end
        held_count = 0;
        byte_sum   = '0;
    endfunction

    function automatic void apply_request(input tbf_pkg::in_item_t r);
        case (r.req_type)
            tbf_pkg::REQ_START: begin
                blk_type   = r.block_type;
                held_count = 0;
                byte_sum   = '0;
            end
            tbf_pkg::REQ_DATA: begin
                payload_mem[held_count] = r.data_byte;
                held_count++;
                byte_sum += r.data_byte;
                if (held_count == tbf_pkg::MAX_PAYLOAD_DEF)
                    send_frame();
            end
            tbf_pkg::REQ_END: send_frame();
            default: ;
        endcase
    endfunction

    function automatic void queue_req(input tbf_pkg::req_e kind, input logic [7:0] btype,
                                      input logic [7:0] dbyte, input logic hold);
        queued_req_t q;
        q.hold_for_drain  = hold;
        q.req.req_type    = kind;
        q.req.block_type  = btype;
        q.req.data_byte   = dbyte;
        req_queue.push_back(q);
        if (kind != tbf_pkg::REQ_NONE)
            stim_items++;
    endfunction

    function automatic logic [7:0] pick_block_type();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(0, 12);
    endfunction

    // Sender: one transfer per handshake, random bursts of idle cycles
    int          send_gap  = 0;
    bit          send_calm = 1'b0;
    queued_req_t head_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_request(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (req_queue.size() != 0 &&
                             !(req_queue[0].hold_for_drain && frame_words.size() != 0)) begin
                    head_req = req_queue.pop_front();
                    s_data  <= head_req.req;
                    s_valid <= 1'b1;
                    if (req_queue.size() > TAIL_ITEMS && !send_calm &&
                        $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 17);
                    if ($urandom_range(0, 63) == 0)
                        send_calm = !send_calm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls in bursts, checks each word against the oldest prediction
    int                 recv_gap  = 0;
    bit                 recv_calm = 1'b0;
    tbf_pkg::out_item_t want_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", m_data));
                end else begin
                    want_word = frame_words.pop_front();
                    if (m_data.frame_bytes !== want_word.frame_bytes)
                        report_mismatch($sformatf("word %0d frame_bytes %h, want %h",
                            word_index, m_data.frame_bytes, want_word.frame_bytes));
                    if (m_data.byte_count !== want_word.byte_count)
                        report_mismatch($sformatf("word %0d byte_count %0d, want %0d",
                            word_index, m_data.byte_count, want_word.byte_count));
                    if (m_data.frame_end !== want_word.frame_end)
                        report_mismatch($sformatf("word %0d frame_end %b, want %b",
                            word_index, m_data.frame_end, want_word.frame_end));
                end
                word_index++;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (req_queue.size() > TAIL_ITEMS && !recv_calm &&
                    $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 17);
                if ($urandom_range(0, 99) == 0)
                    recv_calm = !recv_calm;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int seq;
        int kind;
        int n;
        int full_seq;
        int wait_cycles;

        // Directed: empty block straight out of reset, type 0
        queue_req(tbf_pkg::REQ_END, 8'h00, 8'h00, 1'b0);
        queue_req(tbf_pkg::REQ_START, 8'hff, 8'h00, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h00, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'hff, 1'b0);
        queue_req(tbf_pkg::REQ_END, 8'h00, 8'h5a, 1'b0);
        // type survives a send; sender waits for the previous frame first
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h80, 1'b1);
        queue_req(tbf_pkg::REQ_END, 8'hff, 8'hff, 1'b0);
        // restart drops the held bytes
        queue_req(tbf_pkg::REQ_START, 8'h01, 8'h00, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h7f, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h01, 1'b0);
        queue_req(tbf_pkg::REQ_START, 8'h00, 8'hff, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h3c, 1'b0);
        queue_req(tbf_pkg::REQ_END, 8'h00, 8'h00, 1'b0);
        queue_req(tbf_pkg::REQ_NONE, 8'hff, 8'hff, 1'b0);
        // three bytes: frame ends exactly on a word boundary
        queue_req(tbf_pkg::REQ_START, 8'haa, 8'h00, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h11, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h22, 1'b0);
        queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'h33, 1'b0);
        queue_req(tbf_pkg::REQ_END, 8'h00, 8'h00, 1'b0);
        // four bytes: last word carries only the checksum
        queue_req(tbf_pkg::REQ_START, 8'h55, 8'h00, 1'b0);
        repeat (4) queue_req(tbf_pkg::REQ_DATA, 8'h00, 8'($urandom), 1'b0);
        queue_req(tbf_pkg::REQ_END, 8'h00, 8'h00, 1'b0);

        full_seq = $urandom_range(1, 3);
        seq = 0;
        while (stim_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (seq == full_seq) begin
                // fill to the limit; the overflow bytes start the next block
                queue_req(tbf_pkg::REQ_START, pick_block_type(), 8'($urandom), 1'b0);
                n = tbf_pkg::MAX_PAYLOAD_DEF + $urandom_range(0, 5);
                repeat (n)
                    queue_req(tbf_pkg::REQ_DATA, 8'($urandom), 8'($urandom), 1'b0);
                queue_req(tbf_pkg::REQ_END, 8'($urandom), 8'($urandom), 1'b0);
            end else if (kind < 14) begin
                queue_req(tbf_pkg::REQ_START, pick_block_type(), 8'($urandom),
                          $urandom_range(0, 9) == 0);
                repeat (pick_length())
                    queue_req(tbf_pkg::REQ_DATA, 8'($urandom), 8'($urandom), 1'b0);
                queue_req(tbf_pkg::REQ_END, 8'($urandom), 8'($urandom), 1'b0);
            end else if (kind < 16) begin
                repeat (pick_length())
                    queue_req(tbf_pkg::REQ_DATA, 8'($urandom), 8'($urandom), 1'b0);
                queue_req(tbf_pkg::REQ_END, 8'($urandom), 8'($urandom), 1'b0);
            end else if (kind == 16) begin
                queue_req(tbf_pkg::REQ_START, pick_block_type(), 8'($urandom), 1'b0);
                repeat (pick_length())
                    queue_req(tbf_pkg::REQ_DATA, 8'($urandom), 8'($urandom), 1'b0);
            end else if (kind == 17) begin
                queue_req(tbf_pkg::REQ_END, 8'($urandom), 8'($urandom), 1'b0);
            end else if (kind == 18) begin
                repeat ($urandom_range(1, 3))
                    queue_req(tbf_pkg::REQ_NONE, 8'($urandom), 8'($urandom), 1'b0);
            end else begin
                repeat (pick_length())
                    queue_req(tbf_pkg::REQ_DATA, 8'($urandom), 8'($urandom), 1'b0);
            end
            seq++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() != 0 || s_valid)
            @(posedge aclk);
        wait_cycles = 0;
        while (frame_words.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (frame_words.size() != 0)
            report_mismatch($sformatf("%0d frame words never arrived", frame_words.size()));

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
